@@ rtl/core/console_color_escape_parser_core_defines.svh @@
// Assertion macros for the console color escape parser RTL.
// Included by ccep_cmd_queue, which carries concurrent checks; no other dependencies.
`ifndef CONSOLE_COLOR_ESCAPE_PARSER_CORE_DEFINES_SVH
`define CONSOLE_COLOR_ESCAPE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CCEP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CCEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ccep_pkg.sv @@
// Package for the console color escape parser: word types, character codes,
// phase encoding and the color code decode functions. No dependencies.
`default_nettype none

package ccep_pkg;

    localparam int MAX_RESULTS        = 3;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_FORE   = 8'h46;
    localparam logic [7:0] CHAR_BACK   = 8'h42;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;
    localparam logic [7:0] CHAR_LOW_Z  = 8'h7a;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_F   = 8'h46;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5a;
    localparam logic [3:0] HEX_TEN     = 4'd10;

    localparam logic [3:0] RESET_FORE  = 4'd7;
    localparam logic [3:0] RESET_BACK  = 4'd0;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DOLLAR = 2'd1,
        PH_FORE   = 2'd2,
        PH_BACK   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic [3:0] fore_color;
        logic [3:0] back_color;
        logic       run_last;
    } t_out_word;

    // Everything one input word causes: up to three characters in order,
    // all shown with the same colors.
    typedef struct packed {
        logic [1:0]                   count;
        logic [MAX_RESULTS-1:0][7:0] chars;
        logic [3:0]                   fore;
        logic [3:0]                   back;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

    function automatic logic is_code_char(input logic [7:0] c);
        return (c >= CHAR_ZERO  && c <= CHAR_NINE)  ||
               (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ||
               (c >= CHAR_UP_A  && c <= CHAR_UP_Z);
    endfunction

    function automatic logic [3:0] code_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = 4'(c - CHAR_ZERO);
        end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
            v = HEX_TEN + 4'(c - CHAR_LOW_A);
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            v = HEX_TEN + 4'(c - CHAR_UP_A);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ccep_front.sv @@
// Front end: escape phase tracking, color registers, and the command built
// for each accepted input word. Depends on ccep_pkg.
`default_nettype none

module ccep_front
    import ccep_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_word i_in_word,
    output logic          o_cmd_wr,
    output t_cmd          o_cmd
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_fore, n_fore;
    logic [3:0] r_back, n_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_fore  <= RESET_FORE;
            r_back  <= RESET_BACK;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_fore  <= n_fore;
            r_back  <= n_back;
        end
    end

    always_comb begin
        logic [7:0] c;
        logic       last;
        logic       fresh;
        logic [1:0] k;

        c       = i_in_word.in_char;
        last    = i_in_word.end_of_text;
        fresh   = 1'b1;
        k       = 2'd0;
        n_phase = PH_IDLE;
        n_fore  = r_fore;
        n_back  = r_back;
        o_cmd   = '0;

        unique case (r_phase)
            PH_IDLE: begin
            end
            PH_DOLLAR: begin
                if (!last && c == CHAR_FORE) begin
                    n_phase = PH_FORE;
                    fresh   = 1'b0;
                end else if (!last && c == CHAR_BACK) begin
                    n_phase = PH_BACK;
                    fresh   = 1'b0;
                end else begin
                    o_cmd.chars[0] = CHAR_DOLLAR;
                    k              = 2'd1;
                end
            end
            PH_FORE, PH_BACK: begin
                if (is_code_char(c)) begin
                    if (r_phase == PH_FORE) begin
                        n_fore = code_value(c);
                    end else begin
                        n_back = code_value(c);
                    end
                    fresh = 1'b0;
                end else begin
                    // The held prefix goes out as text before the breaking character.
                    o_cmd.chars[0] = CHAR_DOLLAR;
                    o_cmd.chars[1] = (r_phase == PH_FORE) ? CHAR_FORE : CHAR_BACK;
                    k              = 2'd2;
                end
            end
            default: begin
            end
        endcase

        if (fresh) begin
            if (c == CHAR_DOLLAR && !last) begin
                n_phase = PH_DOLLAR;
            end else begin
                o_cmd.chars[k] = c;
                k              = k + 2'd1;
            end
        end

        if (last) begin
            n_phase = PH_IDLE;
        end

        o_cmd.count = k;
        o_cmd.fore  = r_fore;
        o_cmd.back  = r_back;
        o_cmd_wr    = i_accept && (k != 2'd0);
    end

endmodule

`default_nettype wire

@@ rtl/core/ccep_cmd_queue.sv @@
// Short command queue between the front and back ends, held in registers.
// Depends on ccep_pkg and the assertion macro header.
`default_nettype none
`include "console_color_escape_parser_core_defines.svh"

module ccep_cmd_queue
    import ccep_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_wr,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_rd,
    output logic       o_full,
    output t_cmd_head  o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_wr ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_rd ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    `CCEP_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue count exceeds depth")
    `CCEP_ASSERT_IMPLY(a_no_read_empty, i_clk, i_rst_n, i_rd, r_count != '0, "queue read while empty")
    `CCEP_ASSERT_NEXT(a_count_grows, i_clk, i_rst_n, i_wr && !i_rd, r_count == $past(r_count) + CNT_W'(1), "queue count did not grow on write")

endmodule

`default_nettype wire

@@ rtl/core/ccep_back.sv @@
// Back end: steps through the characters of the head command and presents
// one result word at a time in the output register. Depends on ccep_pkg.
`default_nettype none

module ccep_back
    import ccep_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd_head i_head,
    output logic           o_rd,
    input  wire logic      i_pop,
    output logic           o_empty,
    output t_out_word      o_out_word
);

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_out_word  r_out, n_out;
    logic       w_load;
    logic       w_last;

    always_comb begin
        w_load = i_head.valid && (!r_out_valid || i_pop);
        w_last = (r_idx == i_head.cmd.count - 2'd1);
        o_rd   = w_load && w_last;

        n_out.out_char   = i_head.cmd.chars[r_idx];
        n_out.fore_color = i_head.cmd.fore;
        n_out.back_color = i_head.cmd.back;
        n_out.run_last   = w_last;

        n_idx = r_idx;
        if (w_load) begin
            n_idx = w_last ? 2'd0 : r_idx + 2'd1;
        end

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_word = r_out;

endmodule

`default_nettype wire

@@ rtl/core/console_color_escape_parser_core.sv @@
// Console color escape parser. Input words are accepted one per cycle while
// full is low; the front end parses "$F<x>" and "$B<x>" escapes at once and
// queues the characters each word produces in a QUEUE_DEPTH-entry command
// queue. The back end delivers one result word per cycle from its output
// register while pop is high and the queue holds commands, each queued
// character becoming its own result word; input stalls only when the queue
// has filled. An accepted word's characters are written into the queue and
// then loaded into the output register that drives the output ports.
`default_nettype none

module console_color_escape_parser_core
    import ccep_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_word i_in_word,
    output logic          empty,
    input  wire logic     pop,
    output t_out_word     o_out_word
);

    logic      w_accept;
    logic      w_cmd_wr;
    t_cmd      w_cmd;
    logic      w_cmd_rd;
    t_cmd_head w_head;

    assign w_accept = push && !full;

    ccep_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_in_word (i_in_word),
        .o_cmd_wr  (w_cmd_wr),
        .o_cmd     (w_cmd)
    );

    ccep_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_cmd_wr),
        .i_cmd   (w_cmd),
        .i_rd    (w_cmd_rd),
        .o_full  (full),
        .o_head  (w_head)
    );

    ccep_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_rd       (w_cmd_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

@@ tb/ccep_color_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the console color escape parser: predicts the colored characters
// from every accepted input word and compares each popped word against them.
// Depends on ccep_pkg for the word types, character codes and phase encoding.
module ccep_color_checker
    import ccep_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_word  i_in_word,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked,
    output int        o_color_sets
);

    t_phase     esc_phase;
    logic [3:0] fore_now;
    logic [3:0] back_now;
    t_out_word  colored_chars_due[$];

    function automatic logic is_color_code(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [3:0] color_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= "0" && c <= "9") begin
            v = c - "0";
        end else if (c >= "a" && c <= "f") begin
            v = c - "a" + 8'd10;
        end else if (c >= "A" && c <= "F") begin
            v = c - "A" + 8'd10;
        end
        return v[3:0];
    endfunction

    // Work out the characters one input word releases and queue them with the
    // colors in force at that moment.
    task automatic parse_char(input t_in_word w);
        logic [7:0] shown[$];
        logic       fresh;
        t_out_word  o;
        fresh = 1'b1;
        case (esc_phase)
            PH_DOLLAR: begin
                if (!w.end_of_text && w.in_char == CHAR_FORE) begin
                    esc_phase = PH_FORE;
                    fresh = 1'b0;
                end else if (!w.end_of_text && w.in_char == CHAR_BACK) begin
                    esc_phase = PH_BACK;
                    fresh = 1'b0;
                end else begin
                    shown.push_back(CHAR_DOLLAR);
                    esc_phase = PH_IDLE;
                end
            end
            PH_FORE, PH_BACK: begin
                if (is_color_code(w.in_char)) begin
                    if (esc_phase == PH_FORE) begin
                        fore_now = color_of(w.in_char);
                    end else begin
                        back_now = color_of(w.in_char);
                    end
                    o_color_sets++;
                    fresh = 1'b0;
                end else begin
                    shown.push_back(CHAR_DOLLAR);
                    shown.push_back(esc_phase == PH_FORE ? CHAR_FORE : CHAR_BACK);
                end
                esc_phase = PH_IDLE;
            end
            default: begin
            end
        endcase
        if (fresh) begin
            if (w.in_char == CHAR_DOLLAR && !w.end_of_text) begin
                esc_phase = PH_DOLLAR;
            end else begin
                shown.push_back(w.in_char);
            end
        end
        if (w.end_of_text) begin
            esc_phase = PH_IDLE;
        end
        foreach (shown[i]) begin
            o.out_char   = shown[i];
            o.fore_color = fore_now;
            o.back_color = back_now;
            o.run_last   = (i == shown.size() - 1);
            colored_chars_due.push_back(o);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (colored_chars_due.size() == 0) begin
            $error("word popped with nothing expected: char 0x%0h", got.out_char);
            o_fail_count++;
        end else begin
            want = colored_chars_due.pop_front();
            check_field("out_char", want.out_char, got.out_char);
            check_field("fore_color", 8'(want.fore_color), 8'(got.fore_color));
            check_field("back_color", 8'(want.back_color), 8'(got.back_color));
            check_field("run_last", 8'(want.run_last), 8'(got.run_last));
            o_checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            esc_phase = PH_IDLE;
            fore_now  = RESET_FORE;
            back_now  = RESET_BACK;
            colored_chars_due.delete();
        end else begin
            if (i_push && !i_full) begin
                parse_char(i_in_word);
            end
            if (i_pop && !i_empty) begin
                check_word(i_out_word);
            end
        end
        o_pending = colored_chars_due.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top of the console color escape parser testbench: clock, reset, directed and
// random character streams, and the verdict. Needs ccep_pkg, the parser core and
// the checker module.
module tb;
    import ccep_pkg::*;

    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 305;
    localparam int CYCLE_LIMIT    = 200000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop;
    logic      full;
    logic      empty;
    t_in_word  in_word = '0;
    t_out_word out_word;

    int   fail_count;
    int   pending;
    int   checked;
    int   color_sets;
    int   cycles = 0;
    int   sent   = 0;
    logic calm   = 1'b0;

    console_color_escape_parser_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (out_word)
    );

    ccep_color_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_word    (in_word),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_color_sets (color_sets)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int idle_len();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_code_char();
        case ($urandom_range(0, 2))
            0: return CHAR_ZERO + 8'($urandom_range(0, 9));
            1: return CHAR_LOW_A + 8'($urandom_range(0, 25));
            default: return CHAR_UP_A + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic rand_eot();
        return ($urandom_range(0, 9) == 0);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eot);
        int gap;
        gap = idle_len();
        repeat (gap) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push                = 1'b1;
        in_word.in_char     = c;
        in_word.end_of_text = eot;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        sent++;
    endtask

    task automatic send_text(input string s, input logic eot_last);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], eot_last && (i == s.len() - 1));
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        push = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int stall;
        int burst;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = idle_len();
            repeat (stall) begin
                @(negedge i_clk);
                pop = 1'b0;
            end
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                @(negedge i_clk);
                pop = 1'b1;
            end
        end
    end

    initial begin
        int   kind;
        logic paused;
        paused = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Plain characters at the byte extremes, then each kind of escape:
        // complete, repeated dollar, broken, and cut short by the end of string.
        send_text("A", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("$F9x", 1'b0);
        send_text("$Ba", 1'b0);
        send_text("$$F3", 1'b0);
        send_text("$F!", 1'b0);
        send_text("$Q", 1'b0);
        send_text("$", 1'b1);
        send_text("$F", 1'b1);
        send_text("$Bz", 1'b1);

        while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            calm = (sent >= 150 && sent < 200);
            if (!paused && sent >= 240) begin
                drain();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                send_char(CHAR_DOLLAR, 1'b0);
                send_char($urandom_range(0, 1) ? CHAR_FORE : CHAR_BACK, 1'b0);
                send_char(rand_code_char(), rand_eot());
            end else if (kind < 65) begin
                send_char(CHAR_DOLLAR, rand_eot());
                if ($urandom_range(0, 1)) begin
                    send_char($urandom_range(0, 1) ? CHAR_FORE : CHAR_BACK, rand_eot());
                end
                send_char(8'($urandom_range(0, 255)), rand_eot());
            end else begin
                send_char(8'($urandom), rand_eot());
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        $display("Sent %0d input words; checked %0d colored characters, %0d color changes.",
                 sent, checked, color_sets);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ccep_pkg.sv
rtl/core/ccep_front.sv
rtl/core/ccep_cmd_queue.sv
rtl/core/ccep_back.sv
rtl/core/console_color_escape_parser_core.sv
tb/ccep_color_checker.sv
tb/tb.sv
